// ----- hdl/cfrr_pkg.sv -----
package cfrr_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_RECORD_TYPE = 2'd2;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
	localparam logic [7:0] RECORD_TYPE_RST = 8'h30;

	// Item kinds.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int unsigned REC_LEN  = 8;
	localparam logic [31:0] AGE_FULL = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        publish;
		logic [63:0] record;
	} parse_result_t;

	// One byte of reflected CRC-16/ARC, all eight bit steps unrolled.
	function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- hdl/cfrr_if.sv -----
interface cfrr_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  rx_byte;
	logic [31:0] tick_ms;

	modport source(output valid, cmd, rx_byte, tick_ms, input ready);
	modport sink(input valid, cmd, rx_byte, tick_ms, output ready);
endinterface

interface cfrr_result_if;
	logic               valid;
	logic               ready;
	logic               record_valid;
	logic               record_accepted;
	logic signed [15:0] position;
	logic [7:0]         confidence;
	logic [7:0]         status_byte;
	logic [15:0]        frame_sequence;
	logic [15:0]        processing_delay;
	logic [31:0]        record_id;
	logic [31:0]        age;

	modport source(output valid, record_valid, record_accepted, position, confidence,
		status_byte, frame_sequence, processing_delay, record_id, age, input ready);
	modport sink(input valid, record_valid, record_accepted, position, confidence,
		status_byte, frame_sequence, processing_delay, record_id, age, output ready);
endinterface

interface cfrr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/crc_framed_record_receiver.sv -----
// Channel   Role   Payload
// items     sink   cmd, rx_byte, tick_ms
// results   source record_valid, record_accepted, position, confidence, status_byte,
//                  frame_sequence, processing_delay, record_id, age
// cfg       sink   index, data (always ready)
//
// One item per cycle while results are not stalled: an item is registered when it is
// accepted, and when it leaves that register it is parsed, the state is updated and its
// result enters the output register. A stalled result holds the input stage, and the
// input register keeps taking an item whenever the stage ahead moves. Reset restores
// the default sync and type values, the hunting state, an empty record and an age of
// all ones.
module crc_framed_record_receiver #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	cfrr_item_if.sink     items,
	cfrr_result_if.source results,
	cfrr_cfg_if.sink      cfg
);
	import cfrr_pkg::*;

	logic [7:0]    sync_first_q;
	logic [7:0]    sync_second_q;
	logic [7:0]    record_type_q;

	logic          valid_s1;
	logic          cmd_s1;
	logic [7:0]    byte_s1;
	logic [31:0]   ms_s1;
	logic          adv;
	logic          byte_en;
	parse_result_t parse;

	logic [63:0]   rec_q;
	logic [31:0]   rid_q;
	logic [31:0]   age_q;
	logic          have_q;
	logic [63:0]   rec_d;
	logic [31:0]   rid_d;
	logic [31:0]   rid_inc;
	logic [31:0]   age_d;
	logic [32:0]   age_sum;
	logic          have_d;
	logic          accepted;

	logic          valid_s2;
	logic          have_s2;
	logic          acc_s2;
	logic [63:0]   rec_s2;
	logic [31:0]   rid_s2;
	logic [31:0]   age_s2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			record_type_q <= RECORD_TYPE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg.data;
				CFG_SYNC_SECOND: sync_second_q <= cfg.data;
				CFG_RECORD_TYPE: record_type_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign adv         = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready = !valid_s1 || adv;
	assign byte_en     = adv && (cmd_s1 == CMD_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_s1  <= items.cmd;
			byte_s1 <= items.rx_byte;
			ms_s1   <= items.tick_ms;
		end
	end

	cfrr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (byte_en),
		.rx_byte    (byte_s1),
		.sync_first (sync_first_q),
		.sync_second(sync_second_q),
		.record_type(record_type_q),
		.result     (parse)
	);

	assign age_sum = {1'b0, age_q} + {1'b0, ms_s1};
	assign rid_inc = rid_q + 32'd1;

	always_comb begin
		rec_d    = rec_q;
		rid_d    = rid_q;
		age_d    = age_q;
		have_d   = have_q;
		accepted = 1'b0;
		if (cmd_s1 == CMD_BYTE) begin
			if (parse.publish) begin
				accepted = 1'b1;
				rec_d    = parse.record;
				// The id wraps past zero to one.
				rid_d    = (rid_inc == 32'd0) ? 32'd1 : rid_inc;
				age_d    = '0;
				have_d   = 1'b1;
			end
		end else if (age_q != AGE_FULL) begin
			age_d = age_sum[32] ? AGE_FULL : age_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q  <= '0;
			rid_q  <= '0;
			age_q  <= AGE_FULL;
			have_q <= 1'b0;
		end else if (adv) begin
			rec_q  <= rec_d;
			rid_q  <= rid_d;
			age_q  <= age_d;
			have_q <= have_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			have_s2 <= have_d;
			acc_s2  <= accepted;
			rec_s2  <= rec_d;
			rid_s2  <= rid_d;
			age_s2  <= age_d;
		end
	end

	assign results.valid            = valid_s2;
	assign results.record_valid     = have_s2;
	assign results.record_accepted  = acc_s2;
	assign results.position         = signed'(rec_s2[15:0]);
	assign results.confidence       = rec_s2[23:16];
	assign results.status_byte      = rec_s2[31:24];
	assign results.frame_sequence   = rec_s2[47:32];
	assign results.processing_delay = rec_s2[63:48];
	assign results.record_id        = rid_s2;
	assign results.age              = age_s2;

endmodule

// ----- hdl/cfrr_parser.sv -----
module cfrr_parser #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_en,
	input  logic [7:0]              rx_byte,
	input  logic [7:0]              sync_first,
	input  logic [7:0]              sync_second,
	input  logic [7:0]              record_type,
	output cfrr_pkg::parse_result_t result
);
	import cfrr_pkg::*;

	localparam int LW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_SYNC2  = 3'd1;
	localparam logic [2:0] PH_TYPE   = 3'd2;
	localparam logic [2:0] PH_LEN    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CRC_LO = 3'd5;
	localparam logic [2:0] PH_CRC_HI = 3'd6;

	logic [2:0]    phase_q;
	logic [2:0]    phase_d;
	logic [7:0]    type_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] count_q;
	logic [LW:0]   count_inc;
	logic [15:0]   crc_q;
	logic [15:0]   crc_next;
	logic [7:0]    crc_lo_q;
	logic [7:0]    store_q [8];
	logic          publish;

	// The type byte restarts the CRC from zero.
	assign crc_next  = crc16_arc_byte((phase_q == PH_TYPE) ? 16'h0000 : crc_q, rx_byte);
	assign count_inc = {1'b0, count_q} + {{LW{1'b0}}, 1'b1};

	always_comb begin
		phase_d = phase_q;
		publish = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == sync_first) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				// The second-sync test wins when both sync values are equal.
				if (rx_byte == sync_second) phase_d = PH_TYPE;
				else if (rx_byte == sync_first) phase_d = PH_SYNC2;
				else phase_d = PH_HUNT;
			end
			PH_TYPE: phase_d = PH_LEN;
			PH_LEN: begin
				if ({1'b0, rx_byte} > MAX_LEN) phase_d = PH_HUNT;
				else if (rx_byte != 8'h00) phase_d = PH_DATA;
				else phase_d = PH_CRC_LO;
			end
			PH_DATA: begin
				if (count_inc >= {1'b0, len_q}) phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: phase_d = PH_CRC_HI;
			default: begin
				if ({rx_byte, crc_lo_q} == crc_q && type_q == record_type &&
						len_q == LW'(REC_LEN)) begin
					publish = 1'b1;
				end
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_comb begin
		result.publish = publish;
		for (int k = 0; k < 8; k++) begin
			result.record[8*k +: 8] = store_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			type_q   <= '0;
			len_q    <= '0;
			count_q  <= '0;
			crc_q    <= '0;
			crc_lo_q <= '0;
		end else if (byte_en) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_TYPE: begin
					type_q <= rx_byte;
					crc_q  <= crc_next;
				end
				PH_LEN: begin
					len_q   <= rx_byte[LW-1:0];
					count_q <= '0;
					crc_q   <= crc_next;
				end
				PH_DATA: begin
					crc_q   <= crc_next;
					count_q <= count_inc[LW-1:0];
				end
				PH_CRC_LO: crc_lo_q <= rx_byte;
				default: ;
			endcase
		end
	end

	// Only the first eight payload bytes are kept.
	always_ff @(posedge clk) begin
		if (byte_en && phase_q == PH_DATA && count_q < LW'(REC_LEN)) begin
			store_q[count_q[2:0]] <= rx_byte;
		end
	end

endmodule

// ----- hdl/cfrr_checker.sv -----
module cfrr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        record_valid,
	input logic        record_accepted,
	input logic [31:0] record_id,
	input logic [31:0] age
);
	import cfrr_pkg::*;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// A published item restarts the age and carries a nonzero id.
	a_publish_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_accepted |-> record_valid && age == 32'd0 && record_id != 32'd0)
		else $error("published item with wrong id or age");

	a_no_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_valid |-> record_id == 32'd0 && age == AGE_FULL)
		else $error("id or age moved before any record");

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_valid |-> record_id != 32'd0)
		else $error("zero id after a record");

endmodule

bind crc_framed_record_receiver cfrr_checker u_cfrr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.record_valid   (results.record_valid),
	.record_accepted(results.record_accepted),
	.record_id      (results.record_id),
	.age            (results.age)
);
